// ===== src/slpg_pkg.sv =====
// Shared constants, codes and helpers for the status LED pattern generator.
// No dependencies; imported by status_led_pattern_generator.
package slpg_pkg;

    // Tick counter width
    localparam int COUNTER_WIDTH = 32;

    // Field widths
    localparam int MODE_W   = 3;
    localparam int BRIGHT_W = 7;
    localparam int CHAN_W   = 8;
    localparam int PMODE_W  = 4;
    localparam int DETS_W   = 8;
    localparam int RANGE_W  = 16;
    localparam int IN_W     = 32;   // 31 bits of fields, padded to 4 bytes
    localparam int OUT_W    = 32;   // 25 bits of fields, padded to 4 bytes

    // Config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_LED_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_RED   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_GREEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_BLUE  = 3'd4;

    // LED modes
    localparam logic [MODE_W-1:0] MODE_OFF      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STATUS   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DETECT   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TRACK    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LANDING  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ERROR    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CUSTOM   = 3'd6;

    // Brightness: x*b/100 done as (x * b*RECIP) >> RECIP_SHIFT, exact for x*b < 25600
    localparam logic [BRIGHT_W-1:0] BRIGHT_MAX   = 7'd100;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 7'd50;
    localparam int RECIP       = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int SCALE_W     = 20;   // holds 100 * 5243
    localparam int PROD_W      = CHAN_W + SCALE_W;

    // Landing range thresholds
    localparam logic [RANGE_W-1:0] RANGE_NEAR = 16'd500;
    localparam logic [RANGE_W-1:0] RANGE_MID  = 16'd2000;

    // Residue counter widths
    localparam int M60_W = 6;
    localparam int M30_W = 5;
    localparam int M20_W = 5;
    localparam int M10_W = 4;
    localparam int M6_W  = 3;

    typedef struct packed {
        logic r;
        logic g;
        logic b;
    } t_rgb_mask;

    // Full-scale base color picked from the vision mode
    function automatic t_rgb_mask base_colour(input logic [PMODE_W-1:0] pm);
        t_rgb_mask c;
        c = '{r: 1'b1, g: 1'b1, b: 1'b1};
        case (pm) inside
            [4'd0:4'd2]:          c = '{r: 1'b0, g: 1'b0, b: 1'b1};
            4'd3:                 c = '{r: 1'b1, g: 1'b0, b: 1'b1};
            4'd4, 4'd5, 4'd11:    c = '{r: 1'b0, g: 1'b1, b: 1'b1};
            [4'd6:4'd9]:          c = '{r: 1'b1, g: 1'b1, b: 1'b0};
            4'd12, 4'd13:         c = '{r: 1'b0, g: 1'b1, b: 1'b0};
            default:              c = '{r: 1'b1, g: 1'b1, b: 1'b1};
        endcase
        return c;
    endfunction

endpackage

// ===== src/status_led_pattern_generator.sv =====
// Status LED pattern generator: one ticked RGB command per input beat.
// A beat passes S_MUL, then waits in S_OUT until the result register takes it, and
// no new beat is accepted meanwhile. The three channels go one per cycle through a
// single 8x20 multiplier that applies brightness. Synchronous active-low reset
// restores the register defaults (mode status, brightness 50, custom blue) and
// clears the tick counter and the handshake state. Depends on slpg_pkg.
module status_led_pattern_generator
    import slpg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input beat
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [0] pipeline_present, [4:1] pipeline_mode, [5] snapshot_present,
    // [6] tgt_valid, [14:7] det_count, [30:15] tgt_range, [31] zero
    input  logic [IN_W-1:0]       i_s_axis_tdata,
    // result beat
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [0] led_enable, [8:1] red, [16:9] green, [24:17] blue, [31:25] zero
    output logic [OUT_W-1:0]      o_m_axis_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_OUT
    } t_state;

    // Config registers
    logic [MODE_W-1:0]  r_led_mode;
    logic [SCALE_W-1:0] r_bscale;        // saturated brightness * RECIP
    logic [CHAN_W-1:0]  r_custom [3];

    // Tick counter and its residues
    logic [COUNTER_WIDTH-1:0] r_tick;
    logic [M60_W-1:0] r_m60;
    logic [M30_W-1:0] r_m30;
    logic [M20_W-1:0] r_m20;
    logic [M10_W-1:0] r_m10;
    logic [M6_W-1:0]  r_m6;
    logic [COUNTER_WIDTH-1:0] n_tick;
    logic [M60_W-1:0] n_m60;
    logic [M30_W-1:0] n_m30;
    logic [M20_W-1:0] n_m20;
    logic [M10_W-1:0] n_m10;
    logic [M6_W-1:0]  n_m6;

    // Sequencer
    t_state            r_state;
    logic [1:0]        r_ch;
    logic              r_en;
    logic [CHAN_W-1:0] r_col [3];
    logic [CHAN_W-1:0] r_res [3];
    logic              r_m_valid;
    logic [OUT_W-1:0]  r_m_data;
    logic              m_load;

    // Pattern for the incoming beat
    logic              n_en;
    logic [CHAN_W-1:0] n_col [3];

    // Input fields
    logic                pipe;
    logic [PMODE_W-1:0]  pmode;
    logic                snap;
    logic                tv;
    logic [DETS_W-1:0]   dets;
    logic [RANGE_W-1:0]  tgt_range;
    logic                s_accept;

    // Status breathe
    logic [9:0]        phase_x17;
    logic [CHAN_W-1:0] phase;
    logic [CHAN_W-1:0] inten;
    t_rgb_mask         base;
    logic              land_on;

    // Shared brightness multiplier
    logic [PROD_W-1:0] prod;
    logic [CHAN_W-1:0] scaled;

    // Brightness write value, saturated
    logic [BRIGHT_W-1:0] cfg_bright;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    // result register loads once it is free or being drained
    assign m_load = (r_state == S_OUT) && (!r_m_valid || i_m_axis_tready);

    assign pipe      = i_s_axis_tdata[0];
    assign pmode     = i_s_axis_tdata[4:1];
    assign snap      = i_s_axis_tdata[5];
    assign tv        = snap && i_s_axis_tdata[6];
    assign dets      = snap ? i_s_axis_tdata[14:7] : '0;
    assign tgt_range = snap ? i_s_axis_tdata[30:15] : '0;

    assign cfg_bright = (i_cfg_data[BRIGHT_W-1:0] > BRIGHT_MAX) ? BRIGHT_MAX
                                                                : i_cfg_data[BRIGHT_W-1:0];

    // Next tick and residues; all residues restart when the counter wraps to zero
    always_comb begin
        n_tick = r_tick + 1'b1;
        if (&r_tick) begin
            n_m60 = '0;
            n_m30 = '0;
            n_m20 = '0;
            n_m10 = '0;
            n_m6  = '0;
        end else begin
            n_m60 = (r_m60 == M60_W'(59)) ? '0 : r_m60 + 1'b1;
            n_m30 = (r_m30 == M30_W'(29)) ? '0 : r_m30 + 1'b1;
            n_m20 = (r_m20 == M20_W'(19)) ? '0 : r_m20 + 1'b1;
            n_m10 = (r_m10 == M10_W'(9))  ? '0 : r_m10 + 1'b1;
            n_m6  = (r_m6  == M6_W'(5))   ? '0 : r_m6  + 1'b1;
        end
    end

    // Breathe intensity: phase = m60*255/60 = m60*17/4
    always_comb begin
        phase_x17 = {4'd0, n_m60} * 10'd17;
        phase     = phase_x17[9:2];
        if (phase < 8'd128) begin
            inten = {phase[6:0], 1'b0};
        end else begin
            inten = {(~phase[6:0]), 1'b0};   // 2*(255-phase)
        end
        if (pipe) begin
            base = base_colour(pmode);
        end else begin
            base = '{r: 1'b1, g: 1'b1, b: 1'b1};
        end
    end

    // Landing blink, period chosen by range
    always_comb begin
        if (tv) begin
            if (tgt_range != '0 && tgt_range < RANGE_NEAR) begin
                land_on = !n_m20[1];            // period 4
            end else if (tgt_range != '0 && tgt_range < RANGE_MID) begin
                land_on = n_m10 < M10_W'(5);    // period 10
            end else begin
                land_on = n_m20 < M20_W'(10);   // period 20
            end
        end else begin
            land_on = n_m10 < M10_W'(5);
        end
    end

    // Color and enable for this tick, before brightness
    always_comb begin
        n_en     = 1'b0;
        n_col[0] = '0;
        n_col[1] = '0;
        n_col[2] = '0;
        case (r_led_mode)
            MODE_STATUS: begin
                n_en     = 1'b1;
                n_col[0] = base.r ? inten : '0;
                n_col[1] = base.g ? inten : '0;
                n_col[2] = base.b ? inten : '0;
            end
            MODE_DETECT: begin
                if (dets != '0 && n_m6 < M6_W'(3)) begin
                    n_en     = 1'b1;
                    n_col[1] = '1;
                end
            end
            MODE_TRACK: begin
                if (tv) begin
                    n_en     = 1'b1;
                    n_col[1] = '1;
                end else if (n_m30 < M30_W'(15)) begin
                    n_en     = 1'b1;
                    n_col[2] = '1;
                end
            end
            MODE_LANDING: begin
                if (land_on) begin
                    n_en = 1'b1;
                    if (tv) begin
                        n_col[1] = '1;
                    end else begin
                        n_col[0] = '1;
                    end
                end
            end
            MODE_ERROR: begin
                if (n_m6 < M6_W'(3)) begin
                    n_en     = 1'b1;
                    n_col[0] = '1;
                end
            end
            MODE_CUSTOM: begin
                n_en     = 1'b1;
                n_col[0] = r_custom[0];
                n_col[1] = r_custom[1];
                n_col[2] = r_custom[2];
            end
            default: begin
                n_en = 1'b0;
            end
        endcase
    end

    // Shared multiplier: one channel per cycle
    assign prod   = {{SCALE_W{1'b0}}, r_col[r_ch]} * {{CHAN_W{1'b0}}, r_bscale};
    assign scaled = prod[RECIP_SHIFT +: CHAN_W];

    // Config, tick state, sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_mode  <= MODE_STATUS;
            r_bscale    <= SCALE_W'(int'(BRIGHT_RESET) * RECIP);
            r_custom[0] <= '0;
            r_custom[1] <= '0;
            r_custom[2] <= '1;
            r_tick      <= '0;
            r_m60       <= '0;
            r_m30       <= '0;
            r_m20       <= '0;
            r_m10       <= '0;
            r_m6        <= '0;
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    REG_LED_MODE:     r_led_mode  <= i_cfg_data[MODE_W-1:0];
                    REG_BRIGHTNESS:   r_bscale    <= SCALE_W'(cfg_bright * SCALE_W'(RECIP));
                    REG_CUSTOM_RED:   r_custom[0] <= i_cfg_data;
                    REG_CUSTOM_GREEN: r_custom[1] <= i_cfg_data;
                    REG_CUSTOM_BLUE:  r_custom[2] <= i_cfg_data;
                    default: ;
                endcase
            end

            // result register: load a new beat or drain the held one
            if (m_load) begin
                r_m_valid <= 1'b1;
                r_m_data  <= {7'd0, r_res[2], r_res[1], r_res[0], r_en};
            end else if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_tick   <= n_tick;
                        r_m60    <= n_m60;
                        r_m30    <= n_m30;
                        r_m20    <= n_m20;
                        r_m10    <= n_m10;
                        r_m6     <= n_m6;
                        r_en     <= n_en;
                        r_col[0] <= n_col[0];
                        r_col[1] <= n_col[1];
                        r_col[2] <= n_col[2];
                        r_ch     <= '0;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_res[r_ch] <= scaled;
                    if (r_ch == 2'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        r_ch <= r_ch + 1'b1;
                    end
                end
                S_OUT: begin
                    if (m_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // A dark LED never carries color
    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[0]) |-> (o_m_axis_tdata[24:1] == '0))
        else $error("disabled LED beat with nonzero color");

    // Each accepted beat advances the tick counter by exactly one
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_tick == $past(r_tick) + 1'b1))
        else $error("tick counter did not advance by one");

    // The block is busy right after taking a beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_axis_tready)
        else $error("ready again right after an accepted beat");

    // Brightness scale never exceeds full scale
    a_bscale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bscale <= SCALE_W'(int'(BRIGHT_MAX) * RECIP))
        else $error("brightness scale above 100 percent");
`endif

endmodule
